// ----- hw/rtl/srps_pkg.sv -----
// shared types and constants for the sleep / roaming power sequencer
`timescale 1ns / 1ps

package srps_pkg;

    localparam int COUNT_BITS = 15;
    localparam int SECS_W     = 8;
    localparam int REG_COUNT  = 5;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    localparam logic [COUNT_BITS-1:0] CNT_MAX       = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] NONREM_RESET  = COUNT_BITS'(540);
    localparam logic [COUNT_BITS-1:0] REM_RESET     = COUNT_BITS'(60);
    localparam logic [COUNT_BITS-1:0] REM_MIN       = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] ROAM_MIN      = COUNT_BITS'(10);

    typedef enum logic [2:0] {
        REG_NONREM  = 3'd0,
        REG_REM     = 3'd1,
        REG_ROAM    = 3'd2,
        REG_CLOCK   = 3'd3,
        REG_RFDEBUG = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_REQUEST = 2'd1,
        KIND_YIELD   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_SLEEP  = 2'd1,
        MODE_ROAM   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_SLEPT   = 3'd1,
        EV_WOKE    = 3'd2,
        EV_REM_IN  = 3'd3,
        EV_REM_OUT = 3'd4,
        EV_SWAP    = 3'd5,
        EV_TASK    = 3'd6
    } event_t;

    localparam logic [1:0] CLK_LOW    = 2'd0;
    localparam logic [1:0] CLK_NORMAL = 2'd1;
    localparam logic [1:0] CLK_UNUSED = 2'd3;

    localparam logic [1:0] BAUD_RF       = 2'd0;
    localparam logic [1:0] BAUD_RF_DEBUG = 2'd1;
    localparam logic [1:0] BAUD_PHONE    = 2'd2;

    typedef struct packed {
        logic [COUNT_BITS-1:0] nonrem_seconds;
        logic [COUNT_BITS-1:0] rem_seconds;
        logic [COUNT_BITS-1:0] roaming_interval;
        logic [1:0]            default_clock;
        logic                  rf_debug;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [1:0]        requested_mode;
        logic [SECS_W-1:0] interval_seconds;
    } item_t;

    typedef struct packed {
        logic       idle_allowed;
        logic [2:0] event_code;
        logic       receive_enable;
        logic [1:0] baud_select;
        logic       module_select;
        logic       roaming_active;
        logic       in_rem;
        logic       sleeping;
        logic [1:0] clock_level;
        logic       power_on;
    } result_t;

endpackage

// ----- hw/rtl/srps_cfg.sv -----
// configuration register file with apb-style access
`timescale 1ns / 1ps

module srps_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [srps_pkg::ADDR_W-1:0] paddr,
    input  logic [srps_pkg::DATA_W-1:0] pwdata,
    output logic [srps_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output srps_pkg::cfg_t             cfg
);
    import srps_pkg::*;

    cfg_t                  cfg_reg;
    cfg_t                  cfg_next;
    logic                  wr_en;
    logic [2:0]            idx;
    logic [COUNT_BITS-1:0] wval;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[4:2];
    assign wval   = pwdata[COUNT_BITS-1:0];
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_NONREM:  cfg_next.nonrem_seconds = wval;
                REG_REM:     cfg_next.rem_seconds = (wval < REM_MIN) ? REM_MIN : wval;
                REG_ROAM:    cfg_next.roaming_interval = (wval < ROAM_MIN) ? ROAM_MIN : wval;
                REG_CLOCK:   cfg_next.default_clock = pwdata[1:0];
                REG_RFDEBUG: cfg_next.rf_debug = pwdata[0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_NONREM:  prdata = DATA_W'(cfg_reg.nonrem_seconds);
            REG_REM:     prdata = DATA_W'(cfg_reg.rem_seconds);
            REG_ROAM:    prdata = DATA_W'(cfg_reg.roaming_interval);
            REG_CLOCK:   prdata = DATA_W'(cfg_reg.default_clock);
            REG_RFDEBUG: prdata = DATA_W'(cfg_reg.rf_debug);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.nonrem_seconds   <= NONREM_RESET;
            cfg_reg.rem_seconds      <= REM_RESET;
            cfg_reg.roaming_interval <= '0;
            cfg_reg.default_clock    <= CLK_NORMAL;
            cfg_reg.rf_debug         <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hw/rtl/srps_core.sv -----
// sequencer state and single-pass event update
`timescale 1ns / 1ps

module srps_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  srps_pkg::item_t   item,
    input  srps_pkg::cfg_t    cfg,
    output srps_pkg::result_t result
);
    import srps_pkg::*;

    mode_t                 mode_reg, mode_next;
    logic [COUNT_BITS-1:0] sleep_cnt_reg, sleep_cnt_next;
    logic [COUNT_BITS-1:0] roam_cnt_reg, roam_cnt_next;
    logic                  sleep_flag_reg, sleep_flag_next;
    logic                  rem_flag_reg, rem_flag_next;
    logic                  pend_reg, pend_next;
    logic                  roam_flag_reg, roam_flag_next;
    logic                  radio_reg, radio_next;
    logic                  rails_reg, rails_next;
    logic                  clk_low_reg, clk_low_next;
    logic                  rx_reg, rx_next;
    event_t                ev;

    logic [COUNT_BITS:0]   sleep_sum, roam_sum;
    logic [COUNT_BITS-1:0] sleep_sat, roam_sat;
    logic                  rem_now;

    assign sleep_sum = {1'b0, sleep_cnt_reg} + (COUNT_BITS+1)'(item.interval_seconds);
    assign roam_sum  = {1'b0, roam_cnt_reg} + (COUNT_BITS+1)'(item.interval_seconds);
    assign sleep_sat = sleep_sum[COUNT_BITS] ? CNT_MAX : sleep_sum[COUNT_BITS-1:0];
    assign roam_sat  = roam_sum[COUNT_BITS] ? CNT_MAX : roam_sum[COUNT_BITS-1:0];

    always_comb begin
        mode_next       = mode_reg;
        sleep_cnt_next  = sleep_cnt_reg;
        roam_cnt_next   = roam_cnt_reg;
        sleep_flag_next = sleep_flag_reg;
        rem_flag_next   = rem_flag_reg;
        pend_next       = pend_reg;
        roam_flag_next  = roam_flag_reg;
        radio_next      = radio_reg;
        rails_next      = rails_reg;
        clk_low_next    = clk_low_reg;
        rx_next         = rx_reg;
        ev              = EV_NONE;
        case (item.mode)
            KIND_TICK: begin
                case (mode_reg)
                    MODE_SLEEP: begin
                        sleep_cnt_next = sleep_sat;
                        if (rem_flag_reg) begin
                            if (sleep_sat >= cfg.rem_seconds) pend_next = 1'b1;
                        end else if (sleep_sat >= cfg.nonrem_seconds) begin
                            sleep_cnt_next = '0;
                            clk_low_next   = 1'b0;
                            rails_next     = 1'b1;
                            rem_flag_next  = 1'b1;
                            rx_next        = 1'b1;
                            ev             = EV_REM_IN;
                        end
                    end
                    MODE_ROAM: begin
                        if (roam_sat > cfg.roaming_interval) begin
                            radio_next    = ~radio_reg;
                            roam_cnt_next = '0;
                            ev            = EV_SWAP;
                        end else begin
                            roam_cnt_next = roam_sat;
                        end
                    end
                    default: ev = EV_TASK;
                endcase
            end
            KIND_REQUEST: begin
                case (item.requested_mode)
                    MODE_SLEEP: begin
                        if (mode_reg == MODE_ROAM) roam_flag_next = 1'b0;
                        mode_next = MODE_SLEEP;
                        if (!sleep_flag_reg) begin
                            sleep_cnt_next  = '0;
                            rem_flag_next   = 1'b0;
                            sleep_flag_next = 1'b1;
                            rx_next         = 1'b0;
                            rails_next      = 1'b0;
                            clk_low_next    = 1'b1;
                            ev              = EV_SLEPT;
                        end
                    end
                    MODE_ROAM: begin
                        if (mode_reg == MODE_SLEEP && sleep_flag_reg) begin
                            clk_low_next    = 1'b0;
                            sleep_flag_next = 1'b0;
                            rx_next         = 1'b1;
                            ev              = EV_WOKE;
                        end
                        mode_next = MODE_ROAM;
                        if (!roam_flag_reg) begin
                            roam_cnt_next  = '0;
                            roam_flag_next = 1'b1;
                            radio_next     = ~radio_reg;
                            ev             = EV_SWAP;
                        end
                    end
                    default: begin
                        if (mode_reg == MODE_ROAM) begin
                            roam_flag_next = 1'b0;
                        end else if (mode_reg == MODE_SLEEP && sleep_flag_reg) begin
                            clk_low_next    = 1'b0;
                            sleep_flag_next = 1'b0;
                            rx_next         = 1'b1;
                            ev              = EV_WOKE;
                        end
                        mode_next = MODE_NORMAL;
                    end
                endcase
            end
            KIND_YIELD: begin
                if (pend_reg) begin
                    pend_next      = 1'b0;
                    sleep_cnt_next = '0;
                    rx_next        = 1'b0;
                    rem_flag_next  = 1'b0;
                    clk_low_next   = 1'b1;
                    rails_next     = 1'b0;
                    ev             = EV_REM_OUT;
                end
            end
            default: ev = EV_NONE;
        endcase
    end

    always_comb begin
        rem_now               = sleep_flag_next & rem_flag_next;
        result.power_on       = rails_next;
        if (clk_low_next) begin
            result.clock_level = CLK_LOW;
        end else if (cfg.default_clock == CLK_UNUSED) begin
            result.clock_level = CLK_NORMAL;
        end else begin
            result.clock_level = cfg.default_clock;
        end
        result.sleeping       = sleep_flag_next;
        result.in_rem         = rem_now;
        result.roaming_active = roam_flag_next;
        result.module_select  = radio_next;
        if (radio_next) begin
            result.baud_select = BAUD_PHONE;
        end else begin
            result.baud_select = cfg.rf_debug ? BAUD_RF_DEBUG : BAUD_RF;
        end
        result.receive_enable = rx_next;
        result.event_code     = ev;
        result.idle_allowed   = sleep_flag_next & ~rem_now;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_NORMAL;
            sleep_cnt_reg  <= '0;
            roam_cnt_reg   <= '0;
            sleep_flag_reg <= 1'b0;
            rem_flag_reg   <= 1'b0;
            pend_reg       <= 1'b0;
            roam_flag_reg  <= 1'b0;
            radio_reg      <= 1'b0;
            rails_reg      <= 1'b1;
            clk_low_reg    <= 1'b0;
            rx_reg         <= 1'b1;
        end else if (fire) begin
            mode_reg       <= mode_next;
            sleep_cnt_reg  <= sleep_cnt_next;
            roam_cnt_reg   <= roam_cnt_next;
            sleep_flag_reg <= sleep_flag_next;
            rem_flag_reg   <= rem_flag_next;
            pend_reg       <= pend_next;
            roam_flag_reg  <= roam_flag_next;
            radio_reg      <= radio_next;
            rails_reg      <= rails_next;
            clk_low_reg    <= clk_low_next;
            rx_reg         <= rx_next;
        end
    end

    a_sleep_in_sleep_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        sleep_flag_reg |-> mode_reg == MODE_SLEEP)
        else $error("sleep flag set outside sleep mode");

    a_roam_in_roam_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        roam_flag_reg |-> mode_reg == MODE_ROAM)
        else $error("roaming flag set outside roaming mode");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(mode_reg) && $stable(sleep_cnt_reg) && $stable(roam_cnt_reg)
                  && $stable(radio_reg) && $stable(pend_reg))
        else $error("state changed without a transaction");

    a_swap_toggles_radio: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && ev == EV_SWAP |=> radio_reg != $past(radio_reg))
        else $error("module swap did not toggle the radio");

endmodule

// ----- hw/rtl/sleep_roaming_power_sequencer_top.sv -----
// top level: input register, sequencer core, result register and config port
//
//  channel  | direction | contents
//  s_*      | in        | event transaction: tuser kind, tdata request and seconds
//  m_*      | out       | status transaction after each event
//  apb      | in/out    | five configuration registers at byte addresses 0..16
//
// one result per event; an event goes through the input and result registers
// one event accepted per cycle unless m_ stalls, via the single-pass core update
// a stalled m_ side holds its result and the input register holds one more event
// synchronous reset on aresetn low restores state and config, not the data registers
`timescale 1ns / 1ps

module sleep_roaming_power_sequencer_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [srps_pkg::IN_DATA_W-1:0]   s_tdata,  // requested_mode, interval_seconds
    input  logic [srps_pkg::IN_USER_W-1:0]   s_tuser,  // mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // power_on, clock_level, sleeping, in_rem, roaming_active, module_select,
    // baud_select, receive_enable, event_code, idle_allowed
    output logic [srps_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [srps_pkg::ADDR_W-1:0]      paddr,
    input  logic [srps_pkg::DATA_W-1:0]      pwdata,
    output logic [srps_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);
    import srps_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg, in_valid_next;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg, out_valid_next;
    logic    advance;
    logic    fire;
    logic    s_accept;

    assign advance  = ~out_valid_reg | m_tready;
    assign fire     = in_valid_reg & advance;
    assign s_tready = ~in_valid_reg | advance;
    assign s_accept = s_tvalid & s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_reg);

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.mode             <= s_tuser[1:0];
            item_reg.requested_mode   <= s_tdata[1:0];
            item_reg.interval_seconds <= s_tdata[SECS_W+1:2];
        end
        if (fire) begin
            out_reg <= res;
        end
    end

    srps_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srps_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (res)
    );

endmodule
